// ===== rtl/kmm_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Keyed min/max table package
// Shared constants, request and status codes, and the control and status
// bundles that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package kmm_pkg;

   // Default number of table slots.
   localparam int ENTRIES_DEFAULT = 32;

   // Width of the key and value fields.
   localparam int DATA_W = 64;

   // Request codes.
   localparam logic [1:0] REQ_ADD     = 2'd0;
   localparam logic [1:0] REQ_MARKER  = 2'd1;
   localparam logic [1:0] REQ_EXTRACT = 2'd2;
   localparam logic [1:0] REQ_CLEAR   = 2'd3;

   // Result status codes.
   localparam logic [3:0] ST_INSERTED  = 4'd0;
   localparam logic [3:0] ST_UPDATED   = 4'd1;
   localparam logic [3:0] ST_UNCHANGED = 4'd2;
   localparam logic [3:0] ST_FULL      = 4'd3;
   localparam logic [3:0] ST_NULLKEY   = 4'd4;
   localparam logic [3:0] ST_ENTRY     = 4'd5;
   localparam logic [3:0] ST_NULLGROUP = 4'd6;
   localparam logic [3:0] ST_EMPTY     = 4'd7;
   localparam logic [3:0] ST_CLEARED   = 4'd8;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic       capture;     // latch key and value of an add
      logic       set_seen;    // mark the group non-null
      logic       clear;       // empty the table and the group flag
      logic       reply;       // send a one-item result with reply_code
      logic [3:0] reply_code;
      logic       lookup;      // compare the latched key against all filled slots
      logic       resolve;     // decide, write back and reply for an add
      logic       ext_start;   // rewind the extract pointer
      logic       ext_issue;   // read one slot for extract
   } kmm_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic group_seen;
      logic table_empty;
      logic ext_final;         // extract pointer is on the last filled slot
   } kmm_stat_type;

endpackage
`default_nettype wire

// ===== rtl/kmm_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Keyed min/max table controller
// Sequences each request and drives the datapath through command bits.
// ----------------------------------------------------------------------------
module kmm_ctrl (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 start,
   input  wire logic [1:0]           req_type,
   input  wire logic                 req_key_is_null,
   input  wire kmm_pkg::kmm_stat_type stat,
   output logic                      busy,
   output kmm_pkg::kmm_cmd_type      cmd
);
   import kmm_pkg::*;

   localparam logic [2:0] S_IDLE    = 3'd0;
   localparam logic [2:0] S_LOOKUP  = 3'd1;
   localparam logic [2:0] S_RESOLVE = 3'd2;
   localparam logic [2:0] S_EXTRACT = 3'd3;
   localparam logic [2:0] S_DRAIN   = 3'd4;

   logic [2:0] state_ff;
   logic [2:0] state_in;
   logic       accept;

   assign busy   = (state_ff != S_IDLE);
   assign accept = start && !busy;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               case (req_type)
                  REQ_ADD: begin
                     cmd.set_seen = 1'b1;
                     if (req_key_is_null) begin
                        cmd.reply      = 1'b1;
                        cmd.reply_code = ST_NULLKEY;
                     end else begin
                        cmd.capture = 1'b1;
                        state_in    = S_LOOKUP;
                     end
                  end
                  REQ_MARKER: begin
                     cmd.set_seen   = 1'b1;
                     cmd.reply      = 1'b1;
                     cmd.reply_code = ST_UNCHANGED;
                  end
                  REQ_EXTRACT: begin
                     if (!stat.group_seen) begin
                        cmd.reply      = 1'b1;
                        cmd.reply_code = ST_NULLGROUP;
                     end else if (stat.table_empty) begin
                        cmd.reply      = 1'b1;
                        cmd.reply_code = ST_EMPTY;
                     end else begin
                        cmd.ext_start = 1'b1;
                        state_in      = S_EXTRACT;
                     end
                  end
                  default: begin
                     cmd.clear      = 1'b1;
                     cmd.reply      = 1'b1;
                     cmd.reply_code = ST_CLEARED;
                  end
               endcase
            end
         end
         S_LOOKUP: begin
            cmd.lookup = 1'b1;
            state_in   = S_RESOLVE;
         end
         S_RESOLVE: begin
            cmd.resolve = 1'b1;
            state_in    = S_IDLE;
         end
         S_EXTRACT: begin
            cmd.ext_issue = 1'b1;
            if (stat.ext_final) begin
               state_in = S_DRAIN;
            end
         end
         S_DRAIN: begin
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule
`default_nettype wire

// ===== rtl/kmm_datapath.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Keyed min/max table datapath
// Key registers with a parallel compare, value memory, fill count, mode
// register and the registered result port.
// ----------------------------------------------------------------------------
module kmm_datapath #(
   parameter int ENTRIES = kmm_pkg::ENTRIES_DEFAULT
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire kmm_pkg::kmm_cmd_type         cmd,
   output kmm_pkg::kmm_stat_type             stat,
   input  wire logic                         csr_wr_en,
   input  wire logic                         csr_wr_data,
   input  wire logic signed [kmm_pkg::DATA_W-1:0] in_key,
   input  wire logic signed [kmm_pkg::DATA_W-1:0] in_value,
   output logic                              rsp_strobe,
   output logic [3:0]                        rsp_status,
   output logic signed [kmm_pkg::DATA_W-1:0] rsp_out_key,
   output logic signed [kmm_pkg::DATA_W-1:0] rsp_out_value,
   output logic                              rsp_last
);
   import kmm_pkg::*;

   localparam int CW = $clog2(ENTRIES + 1);
   localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

   // Slots fill from zero upward and are only emptied all at once, so the
   // filled slots are always 0 .. count-1.
   logic                     mode_ff;
   logic                     seen_ff;
   logic [CW-1:0]            count_ff;
   logic signed [DATA_W-1:0] key_in_ff;
   logic signed [DATA_W-1:0] val_in_ff;
   logic signed [DATA_W-1:0] key_ff [ENTRIES];
   logic signed [DATA_W-1:0] value_mem [ENTRIES];
   logic signed [DATA_W-1:0] value_rd_ff;
   logic signed [DATA_W-1:0] key_rd_ff;
   logic                     hit_ff;
   logic [IW-1:0]            hit_idx_ff;
   logic [IW-1:0]            ext_idx_ff;
   logic                     pend_ff;
   logic                     pend_last_ff;

   logic                     match_any;
   logic [IW-1:0]            match_idx;
   logic [IW-1:0]            rd_addr;
   logic                     better;
   logic                     full;
   logic [3:0]               resolve_code;
   logic                     wr_en;
   logic [IW-1:0]            wr_addr;
   logic                     insert;

   logic                     rsp_strobe_ff, rsp_strobe_in;
   logic [3:0]               rsp_status_ff, rsp_status_in;
   logic signed [DATA_W-1:0] rsp_key_ff, rsp_key_in;
   logic signed [DATA_W-1:0] rsp_value_ff, rsp_value_in;
   logic                     rsp_last_ff, rsp_last_in;

   // Parallel key compare. Stored keys are unique, so at most one slot hits
   // and the index is an OR of the hitting slot numbers.
   always_comb begin
      match_any = 1'b0;
      match_idx = '0;
      for (int i = 0; i < ENTRIES; i++) begin
         if ((CW'(i) < count_ff) && (key_ff[i] == key_in_ff)) begin
            match_any = 1'b1;
            match_idx = match_idx | IW'(i);
         end
      end
   end

   assign rd_addr = cmd.lookup ? match_idx : ext_idx_ff;

   assign full   = (count_ff == CW'(ENTRIES));
   assign better = mode_ff ? (value_rd_ff < val_in_ff) : (val_in_ff < value_rd_ff);
   assign insert = cmd.resolve && !hit_ff && !full;
   assign wr_en  = insert || (cmd.resolve && hit_ff && better);
   assign wr_addr = hit_ff ? hit_idx_ff : count_ff[IW-1:0];

   always_comb begin
      if (hit_ff) begin
         resolve_code = better ? ST_UPDATED : ST_UNCHANGED;
      end else begin
         resolve_code = full ? ST_FULL : ST_INSERTED;
      end
   end

   assign stat.group_seen  = seen_ff;
   assign stat.table_empty = (count_ff == '0);
   assign stat.ext_final   = (CW'(ext_idx_ff) == (count_ff - CW'(1)));

   // Value memory: one write port, one registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         value_mem[wr_addr] <= val_in_ff;
      end
      value_rd_ff <= value_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (insert) begin
         key_ff[count_ff[IW-1:0]] <= key_in_ff;
      end
      if (cmd.capture) begin
         key_in_ff <= in_key;
         val_in_ff <= in_value;
      end
      if (cmd.lookup) begin
         hit_idx_ff <= match_idx;
      end
      key_rd_ff <= key_ff[ext_idx_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= 1'b0;
         seen_ff      <= 1'b0;
         count_ff     <= '0;
         hit_ff       <= 1'b0;
         ext_idx_ff   <= '0;
         pend_ff      <= 1'b0;
         pend_last_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            mode_ff <= csr_wr_data;
         end
         if (cmd.clear) begin
            seen_ff  <= 1'b0;
            count_ff <= '0;
         end else begin
            if (cmd.set_seen) begin
               seen_ff <= 1'b1;
            end
            if (insert) begin
               count_ff <= count_ff + CW'(1);
            end
         end
         if (cmd.lookup) begin
            hit_ff <= match_any;
         end
         if (cmd.ext_start) begin
            ext_idx_ff <= '0;
         end else if (cmd.ext_issue) begin
            ext_idx_ff <= ext_idx_ff + IW'(1);
         end
         pend_ff      <= cmd.ext_issue;
         pend_last_ff <= cmd.ext_issue && stat.ext_final;
      end
   end

   // Result register.
   always_comb begin
      rsp_strobe_in = 1'b0;
      rsp_status_in = rsp_status_ff;
      rsp_key_in    = '0;
      rsp_value_in  = '0;
      rsp_last_in   = 1'b1;
      if (cmd.reply) begin
         rsp_strobe_in = 1'b1;
         rsp_status_in = cmd.reply_code;
      end else if (cmd.resolve) begin
         rsp_strobe_in = 1'b1;
         rsp_status_in = resolve_code;
      end else if (pend_ff) begin
         rsp_strobe_in = 1'b1;
         rsp_status_in = ST_ENTRY;
         rsp_key_in    = key_rd_ff;
         rsp_value_in  = value_rd_ff;
         rsp_last_in   = pend_last_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= rsp_strobe_in;
      end
      rsp_status_ff <= rsp_status_in;
      rsp_key_ff    <= rsp_key_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_strobe    = rsp_strobe_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_out_key   = rsp_key_ff;
   assign rsp_out_value = rsp_value_ff;
   assign rsp_last      = rsp_last_ff;

endmodule
`default_nettype wire

// ===== rtl/keyed_min_max_table_top.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Keyed min/max table
// Bounded key-to-value table for one aggregation group, keeping the per-key
// minimum or maximum value, with extract and clear.
// ----------------------------------------------------------------------------
// An item is accepted when start is high and busy is low. Every result is
// shown for exactly one cycle with rsp_strobe high and must be taken then;
// the block cannot be stalled from the result side, and rsp_last marks the
// final result of an item. An add with a non-null key keeps busy high
// through a lookup step, which compares the key against every filled slot
// in parallel and reads the matching value from the value memory, and a
// resolve step, which compares the values and writes back. Null-key adds,
// empty-map markers, clears and extracts of a null group or an empty table
// answer in the next cycle and leave busy low. An extract of N stored
// entries streams one entry per cycle, limited by the single read port of
// the value memory, and keeps busy high while it streams. The mode register
// (csr_wr_data, 0 for minimum, 1 for maximum) is written with csr_wr_en and
// must only change while the block is idle. Slots fill in order and are
// emptied only by a clear, so no clearing pass is needed after reset.
// ----------------------------------------------------------------------------
module keyed_min_max_table_top #(
   parameter int ENTRIES = kmm_pkg::ENTRIES_DEFAULT
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              start,
   output logic                                   busy,
   input  wire logic [1:0]                        req_type,
   input  wire logic signed [kmm_pkg::DATA_W-1:0] req_in_key,
   input  wire logic signed [kmm_pkg::DATA_W-1:0] req_in_value,
   input  wire logic                              req_key_is_null,
   output logic                                   rsp_strobe,
   output logic [3:0]                             rsp_status,
   output logic signed [kmm_pkg::DATA_W-1:0]      rsp_out_key,
   output logic signed [kmm_pkg::DATA_W-1:0]      rsp_out_value,
   output logic                                   rsp_last,
   input  wire logic                              csr_wr_en,
   input  wire logic                              csr_wr_data
);
   import kmm_pkg::*;

   kmm_cmd_type  cmd;
   kmm_stat_type stat;

   // The controller owns sequencing; the datapath owns all storage.
   kmm_ctrl u_ctrl (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .req_type        (req_type),
      .req_key_is_null (req_key_is_null),
      .stat            (stat),
      .busy            (busy),
      .cmd             (cmd)
   );

   kmm_datapath #(
      .ENTRIES (ENTRIES)
   ) u_datapath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .stat          (stat),
      .csr_wr_en     (csr_wr_en),
      .csr_wr_data   (csr_wr_data),
      .in_key        (req_in_key),
      .in_value      (req_in_value),
      .rsp_strobe    (rsp_strobe),
      .rsp_status    (rsp_status),
      .rsp_out_key   (rsp_out_key),
      .rsp_out_value (rsp_out_value),
      .rsp_last      (rsp_last)
   );

`ifndef NO_ASSERTIONS
   // An add with a real key occupies the block until its result is out.
   a_add_holds_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy && (req_type == REQ_ADD) && !req_key_is_null
      |=> busy ##1 (busy && !rsp_strobe) ##1 (rsp_strobe && rsp_last))
      else $error("add did not complete in the expected three cycles");

   // A marker always answers unchanged on the next cycle.
   a_marker_reply: assert property (@(posedge clock) disable iff (reset)
      start && !busy && (req_type == REQ_MARKER)
      |=> rsp_strobe && (rsp_status == ST_UNCHANGED) && rsp_last)
      else $error("marker reply missing or wrong");

   // Only listed entries carry key or value data; everything else is final.
   a_non_entry_final: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && (rsp_status != ST_ENTRY)
      |-> rsp_last && (rsp_out_key == '0) && (rsp_out_value == '0))
      else $error("non-entry result carries data or is not final");

   // While idle there is no extract stream left to finish.
   a_idle_no_stream: assert property (@(posedge clock) disable iff (reset)
      !busy && !$past(busy) && rsp_strobe |-> rsp_last)
      else $error("entry stream still running while idle");
`endif

endmodule
`default_nettype wire
